### hw/rtl/cbic_pkg.sv
// Shared types and constants for the cartridge bank and IRQ controller.
// No dependencies.
package cbic_pkg;

  typedef enum logic {
    OP_WRITE = 1'b0,
    OP_TICK  = 1'b1
  } op_t;

  localparam logic [15:0] ADDR_MIRROR  = 16'h42FF;
  localparam logic [15:0] ADDR_ONESCR  = 16'h42FE;
  localparam logic [15:0] ADDR_IRQ_ACK = 16'h4501;
  localparam logic [15:0] ADDR_CNT_LO  = 16'h4502;
  localparam logic [15:0] ADDR_CNT_HI  = 16'h4503;

  localparam logic [1:0] SRC_ROM   = 2'd0;
  localparam logic [1:0] SRC_RAM   = 2'd1;
  localparam logic [1:0] SRC_EXTRA = 2'd2;

  typedef struct packed {
    op_t         operation;
    logic [15:0] address;
    logic [7:0]  data;
    logic [7:0]  cycles;
  } item_t;

  typedef struct packed {
    logic [5:0] prg_bank;
    logic [1:0] chr_source;
    logic [7:0] chr_bank;
    logic [1:0] mirror_setting;
    logic       irq_line;
  } result_t;

endpackage

### hw/rtl/cbic_in_stage.sv
// Input register stage: holds one accepted transfer for the decode stage.
// Depends on cbic_pkg.
module cbic_in_stage (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           in_valid,
  output logic           in_ready,
  input  cbic_pkg::item_t in_item,
  output logic           item_valid,
  input  logic           item_take,
  output cbic_pkg::item_t item
);
  import cbic_pkg::*;

  logic  vld_r;
  logic  vld_nxt;
  item_t item_r;

  assign in_ready   = !vld_r || item_take;
  assign item_valid = vld_r;
  assign item       = item_r;

  always_comb begin
    vld_nxt = vld_r;
    if (in_valid && in_ready) begin
      vld_nxt = 1'b1;
    end else if (item_take) begin
      vld_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= 1'b0;
    end else begin
      vld_r <= vld_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      item_r <= in_item;
    end
  end

endmodule

### hw/rtl/cbic_core.sv
// Mapper state: write decode, IRQ counter and the result register.
// Depends on cbic_pkg.
module cbic_core (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             item_valid,
  output logic             item_take,
  input  cbic_pkg::item_t  item,
  output logic             res_valid,
  input  logic             res_ready,
  output cbic_pkg::result_t res
);
  import cbic_pkg::*;

  logic        mode_r,     mode_nxt;
  logic        irq_en_r,   irq_en_nxt;
  logic [15:0] cnt_r,      cnt_nxt;
  logic        pend_r,     pend_nxt;
  logic [5:0]  prg_r,      prg_nxt;
  logic [1:0]  src_r,      src_nxt;
  logic [7:0]  chr_r,      chr_nxt;
  logic [1:0]  mir_r,      mir_nxt;
  logic        res_vld_r,  res_vld_nxt;
  result_t     res_r;
  logic [16:0] sum;

  assign item_take = item_valid && (!res_vld_r || res_ready);
  assign res_valid = res_vld_r;
  assign res       = res_r;
  assign sum       = {1'b0, cnt_r} + {9'd0, item.cycles};

  always_comb begin
    mode_nxt   = mode_r;
    irq_en_nxt = irq_en_r;
    cnt_nxt    = cnt_r;
    pend_nxt   = pend_r;
    prg_nxt    = prg_r;
    src_nxt    = src_r;
    chr_nxt    = chr_r;
    mir_nxt    = mir_r;
    if (item.operation == OP_TICK) begin
      if (irq_en_r) begin
        if (sum[16]) begin
          pend_nxt   = 1'b1;
          irq_en_nxt = 1'b0;
          cnt_nxt    = '0;
        end else begin
          cnt_nxt = sum[15:0];
        end
      end
    end else if (item.address[15]) begin
      if (mode_r) begin
        src_nxt = SRC_ROM;
        chr_nxt = item.data;
      end else begin
        prg_nxt = item.data[7:2];
        src_nxt = (item.data[1:0] != 2'd0) ? SRC_EXTRA : SRC_RAM;
        chr_nxt = {6'd0, item.data[1:0]};
      end
    end else begin
      priority if (item.address == ADDR_MIRROR) begin
        mir_nxt = {1'b0, item.data[4]};
      end else if (item.address == ADDR_ONESCR) begin
        mir_nxt  = {1'b1, item.data[4]};
        mode_nxt = item.data[7];
      end else if (item.address == ADDR_IRQ_ACK) begin
        irq_en_nxt = 1'b0;
        pend_nxt   = 1'b0;
      end else if (item.address == ADDR_CNT_LO) begin
        cnt_nxt = {cnt_r[15:8], item.data};
      end else if (item.address == ADDR_CNT_HI) begin
        cnt_nxt    = {item.data, cnt_r[7:0]};
        irq_en_nxt = 1'b1;
      end else begin
        cnt_nxt = cnt_r;
      end
    end
  end

  always_comb begin
    res_vld_nxt = res_vld_r;
    if (item_take) begin
      res_vld_nxt = 1'b1;
    end else if (res_ready) begin
      res_vld_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r    <= 1'b0;
      irq_en_r  <= 1'b0;
      cnt_r     <= '0;
      pend_r    <= 1'b0;
      prg_r     <= '0;
      src_r     <= '0;
      chr_r     <= '0;
      mir_r     <= '0;
      res_vld_r <= 1'b0;
    end else begin
      res_vld_r <= res_vld_nxt;
      if (item_take) begin
        mode_r   <= mode_nxt;
        irq_en_r <= irq_en_nxt;
        cnt_r    <= cnt_nxt;
        pend_r   <= pend_nxt;
        prg_r    <= prg_nxt;
        src_r    <= src_nxt;
        chr_r    <= chr_nxt;
        mir_r    <= mir_nxt;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (item_take) begin
      res_r.prg_bank       <= prg_nxt;
      res_r.chr_source     <= src_nxt;
      res_r.chr_bank       <= chr_nxt;
      res_r.mirror_setting <= mir_nxt;
      res_r.irq_line       <= pend_nxt;
    end
  end

endmodule

### hw/rtl/cartridge_bank_irq_controller.sv
// Top level of the cartridge bank and IRQ controller.
// Depends on cbic_pkg, cbic_in_stage and cbic_core.
//
//   port group  | direction | handshake           | payload
//   in_*        | input     | in_valid/in_ready   | operation, address, data, cycles
//   out_*       | output    | out_valid/out_ready | prg_bank, chr_source, chr_bank,
//               |           |                     | mirror_setting, irq_line
//
// One transfer per clock sustained while out_ready stays high; an accepted transfer
// passes from the input register through decode and counter add into the result
// register, which raises out_valid.
// Synchronous active-low reset clears all mapper state and both valid flags.
// A stalled output holds its result; the input register can still take one transfer
// while the result waits, then stalls until out_ready returns.
module cartridge_bank_irq_controller (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic        in_operation,
  input  logic [15:0] in_address,
  input  logic [7:0]  in_data,
  input  logic [7:0]  in_cycles,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [5:0]  out_prg_bank,
  output logic [1:0]  out_chr_source,
  output logic [7:0]  out_chr_bank,
  output logic [1:0]  out_mirror_setting,
  output logic        out_irq_line
);
  import cbic_pkg::*;

  item_t   in_item;
  item_t   item;
  logic    item_valid;
  logic    item_take;
  result_t res;

  assign in_item.operation = op_t'(in_operation);
  assign in_item.address   = in_address;
  assign in_item.data      = in_data;
  assign in_item.cycles    = in_cycles;

  cbic_in_stage u_in_stage (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_item   (in_item),
    .item_valid(item_valid),
    .item_take (item_take),
    .item      (item)
  );

  cbic_core u_core (
    .clk       (clk),
    .rst_n     (rst_n),
    .item_valid(item_valid),
    .item_take (item_take),
    .item      (item),
    .res_valid (out_valid),
    .res_ready (out_ready),
    .res       (res)
  );

  assign out_prg_bank       = res.prg_bank;
  assign out_chr_source     = res.chr_source;
  assign out_chr_bank       = res.chr_bank;
  assign out_mirror_setting = res.mirror_setting;
  assign out_irq_line       = res.irq_line;

endmodule

### test/tb.sv
`timescale 1ns / 100ps
// Testbench for cartridge_bank_irq_controller: directed decode and IRQ counter cases,
// back-pressure, counter wrap sequences and random bus traffic, checked against a
// shadow model of the mapper state. Depends on cbic_pkg and the controller RTL.
module tb;
  import cbic_pkg::*;

  localparam int unsigned CYCLE_LIMIT = 400000;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_valid = 1'b0;
  logic        in_ready;
  logic        in_operation = 1'b0;
  logic [15:0] in_address = '0;
  logic [7:0]  in_data = '0;
  logic [7:0]  in_cycles = '0;
  logic        out_valid;
  logic        out_ready = 1'b0;
  logic [5:0]  out_prg_bank;
  logic [1:0]  out_chr_source;
  logic [7:0]  out_chr_bank;
  logic [1:0]  out_mirror_setting;
  logic        out_irq_line;

  // shadow mapper state
  logic        sh_mode;
  logic        sh_irq_en;
  logic [15:0] sh_count;
  logic        sh_irq_pend;
  logic [5:0]  sh_prg;
  logic [1:0]  sh_src;
  logic [7:0]  sh_chr;
  logic [1:0]  sh_mirror;

  result_t     mapper_out_q[$];
  result_t     seen_out;
  result_t     want_out;
  int unsigned mismatches = 0;
  int unsigned items_sent = 0;
  int unsigned cycle_count = 0;
  bit          send_gaps_on = 1'b0;
  bit          recv_stalls_on = 1'b0;
  int unsigned hold_request = 0;
  int unsigned hold_left = 0;
  int unsigned stall_left = 0;
  int unsigned recv_gap;

  cartridge_bank_irq_controller u_dut (
    .clk               (clk),
    .rst_n             (rst_n),
    .in_valid          (in_valid),
    .in_ready          (in_ready),
    .in_operation      (in_operation),
    .in_address        (in_address),
    .in_data           (in_data),
    .in_cycles         (in_cycles),
    .out_valid         (out_valid),
    .out_ready         (out_ready),
    .out_prg_bank      (out_prg_bank),
    .out_chr_source    (out_chr_source),
    .out_chr_bank      (out_chr_bank),
    .out_mirror_setting(out_mirror_setting),
    .out_irq_line      (out_irq_line)
  );

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  function automatic int unsigned pick_gap();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 60) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  function automatic item_t make_write(input logic [15:0] addr, input logic [7:0] val);
    item_t it;
    it.operation = OP_WRITE;
    it.address   = addr;
    it.data      = val;
    it.cycles    = 8'($urandom_range(0, 255));
    return it;
  endfunction

  function automatic item_t make_tick(input logic [7:0] n);
    item_t it;
    it.operation = OP_TICK;
    it.address   = 16'($urandom_range(0, 16'hFFFF));
    it.data      = 8'($urandom_range(0, 255));
    it.cycles    = n;
    return it;
  endfunction

  function automatic item_t random_item();
    item_t       it;
    int unsigned r;
    it.operation = op_t'(1'($urandom_range(0, 1)));
    it.address   = 16'($urandom_range(0, 16'hFFFF));
    it.data      = 8'($urandom_range(0, 255));
    it.cycles    = 8'($urandom_range(0, 255));
    r = $urandom_range(0, 99);
    if (r < 25) begin
      it.operation = OP_TICK;
    end else if (r < 45) begin
      it.operation = OP_WRITE;
      it.address   = {1'b1, it.address[14:0]};
    end else if (r < 55) begin
      it.operation = OP_WRITE;
      it.address   = $urandom_range(0, 1) ? ADDR_MIRROR : ADDR_ONESCR;
    end else if (r < 70) begin
      it.operation = OP_WRITE;
      case ($urandom_range(0, 2))
        0:       it.address = ADDR_CNT_LO;
        1:       it.address = ADDR_CNT_HI;
        default: it.address = ADDR_IRQ_ACK;
      endcase
    end
    return it;
  endfunction

  task automatic predict_mapper(input item_t it);
    logic [16:0] sum;
    result_t     r;
    if (it.operation == OP_TICK) begin
      if (sh_irq_en) begin
        sum = {1'b0, sh_count} + {9'd0, it.cycles};
        if (sum[16]) begin
          sh_irq_pend = 1'b1;
          sh_irq_en   = 1'b0;
          sh_count    = '0;
        end else begin
          sh_count = sum[15:0];
        end
      end
    end else if (!it.address[15]) begin
      case (it.address)
        ADDR_MIRROR:  sh_mirror = {1'b0, it.data[4]};
        ADDR_ONESCR: begin
          sh_mirror = {1'b1, it.data[4]};
          sh_mode   = it.data[7];
        end
        ADDR_IRQ_ACK: begin
          sh_irq_en   = 1'b0;
          sh_irq_pend = 1'b0;
        end
        ADDR_CNT_LO:  sh_count[7:0] = it.data;
        ADDR_CNT_HI: begin
          sh_count[15:8] = it.data;
          sh_irq_en      = 1'b1;
        end
        default: ;
      endcase
    end else if (sh_mode) begin
      sh_src = SRC_ROM;
      sh_chr = it.data;
    end else begin
      sh_prg = it.data[7:2];
      sh_src = (it.data[1:0] != 2'd0) ? SRC_EXTRA : SRC_RAM;
      sh_chr = {6'd0, it.data[1:0]};
    end
    r.prg_bank       = sh_prg;
    r.chr_source     = sh_src;
    r.chr_bank       = sh_chr;
    r.mirror_setting = sh_mirror;
    r.irq_line       = sh_irq_pend;
    mapper_out_q.push_back(r);
  endtask

  task automatic send_item(input item_t it);
    int unsigned gap;
    gap = send_gaps_on ? pick_gap() : 0;
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid     <= 1'b1;
    in_operation <= it.operation;
    in_address   <= it.address;
    in_data      <= it.data;
    in_cycles    <= it.cycles;
    do @(posedge clk); while (!in_ready);
    predict_mapper(it);
    items_sent++;
  endtask

  task automatic wait_drain();
    in_valid <= 1'b0;
    while (mapper_out_q.size() != 0) @(posedge clk);
  endtask

  task automatic note_failure(input string msg);
    mismatches++;
    if (mismatches <= 10) $display("%0t: %s", $realtime, msg);
  endtask

  // result checker
  always @(posedge clk) begin
    if (rst_n && out_valid && out_ready) begin
      seen_out = '{out_prg_bank, out_chr_source, out_chr_bank, out_mirror_setting,
                   out_irq_line};
      if (mapper_out_q.size() == 0) begin
        note_failure($sformatf("unexpected transfer prg=%0d src=%0d chr=%0d mir=%0d irq=%0b",
                               seen_out.prg_bank, seen_out.chr_source, seen_out.chr_bank,
                               seen_out.mirror_setting, seen_out.irq_line));
      end else begin
        want_out = mapper_out_q.pop_front();
        if (seen_out.prg_bank !== want_out.prg_bank ||
            seen_out.chr_source !== want_out.chr_source ||
            seen_out.chr_bank !== want_out.chr_bank ||
            seen_out.mirror_setting !== want_out.mirror_setting ||
            seen_out.irq_line !== want_out.irq_line) begin
          note_failure($sformatf({"mismatch exp prg=%0d src=%0d chr=%0d mir=%0d irq=%0b",
                                  " got prg=%0d src=%0d chr=%0d mir=%0d irq=%0b"},
                                 want_out.prg_bank, want_out.chr_source, want_out.chr_bank,
                                 want_out.mirror_setting, want_out.irq_line,
                                 seen_out.prg_bank, seen_out.chr_source, seen_out.chr_bank,
                                 seen_out.mirror_setting, seen_out.irq_line));
        end
      end
    end
  end

  // receiver: long holds on request, otherwise random stalls
  always @(posedge clk) begin
    if (hold_request > 0) begin
      hold_left    = hold_request;
      hold_request = 0;
    end
    if (hold_left > 0) begin
      hold_left--;
      out_ready <= 1'b0;
    end else if (stall_left > 0) begin
      stall_left--;
      out_ready <= 1'b0;
    end else begin
      recv_gap = recv_stalls_on ? pick_gap() : 0;
      if (recv_gap > 0) begin
        stall_left = recv_gap - 1;
        out_ready <= 1'b0;
      end else begin
        out_ready <= 1'b1;
      end
    end
  end

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("TEST FAILED");
      $finish;
    end
  end

  task automatic test_decode_cases();
    send_item(make_tick(8'hFF));
    send_item(make_write(ADDR_MIRROR, 8'h10));
    send_item(make_write(ADDR_MIRROR, 8'hEF));
    send_item(make_write(ADDR_ONESCR, 8'h90));
    send_item(make_write(16'hFFFF, 8'hFF));
    send_item(make_write(16'h8000, 8'h00));
    send_item(make_write(ADDR_ONESCR, 8'h6F));
    send_item(make_write(16'h8000, 8'hFC));
    send_item(make_write(16'hC3A5, 8'h03));
    send_item(make_write(16'h8001, 8'h02));
    send_item(make_write(16'h7FFF, 8'hFF));
    send_item(make_write(16'h0000, 8'hFF));
    send_item(make_write(16'h4500, 8'hFF));
    send_item(make_write(16'h4504, 8'hFF));
    wait_drain();
  endtask

  task automatic test_irq_counter_edges();
    send_item(make_write(ADDR_CNT_LO, 8'hF0));
    send_item(make_write(ADDR_CNT_HI, 8'hFF));
    send_item(make_tick(8'h00));
    send_item(make_tick(8'h0F));
    send_item(make_tick(8'h01));
    send_item(make_tick(8'hFF));
    send_item(make_write(ADDR_CNT_HI, 8'h00));
    send_item(make_tick(8'hFF));
    send_item(make_write(ADDR_IRQ_ACK, 8'h00));
    send_item(make_tick(8'hFF));
    wait_drain();
  endtask

  // output held off while the sender keeps offering back-to-back transfers
  task automatic test_backpressure();
    int i;
    send_gaps_on = 1'b0;
    hold_request = 300;
    for (i = 0; i < 40; i++) send_item(random_item());
    wait_drain();
    send_gaps_on = 1'b1;
  endtask

  task automatic test_irq_wrap_sequences();
    int unsigned start;
    int unsigned steps;
    start = items_sent;
    while (items_sent - start < 700) begin
      send_item(make_write(ADDR_CNT_LO, 8'($urandom_range(0, 255))));
      send_item(make_write(ADDR_CNT_HI, ($urandom_range(0, 4) != 0) ?
                                        8'($urandom_range(8'hF0, 8'hFF)) :
                                        8'($urandom_range(0, 255))));
      steps = 0;
      while (sh_irq_en && steps < 100) begin
        if ($urandom_range(0, 3) != 0)
          send_item(make_tick($urandom_range(0, 1) ? 8'($urandom_range(128, 255)) :
                                                     8'($urandom_range(0, 255))));
        else
          send_item(random_item());
        steps++;
      end
      if (sh_irq_pend && $urandom_range(0, 1))
        send_item(make_write(ADDR_CNT_HI, 8'($urandom_range(0, 255))));
      if ($urandom_range(0, 3) != 0)
        send_item(make_write(ADDR_IRQ_ACK, 8'($urandom_range(0, 255))));
    end
    wait_drain();
  endtask

  task automatic test_random_traffic();
    int i;
    for (i = 0; i < 1000; i++) begin
      if (i % 100 == 0) begin
        send_gaps_on   = $urandom_range(0, 3) != 0;
        recv_stalls_on = $urandom_range(0, 3) != 0;
      end
      if (i % 250 == 249) wait_drain();
      send_item(random_item());
    end
    wait_drain();
  endtask

  initial begin
    sh_mode     = 1'b0;
    sh_irq_en   = 1'b0;
    sh_count    = '0;
    sh_irq_pend = 1'b0;
    sh_prg      = '0;
    sh_src      = SRC_ROM;
    sh_chr      = '0;
    sh_mirror   = '0;
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    send_gaps_on   = 1'b1;
    recv_stalls_on = 1'b1;
    test_decode_cases();
    test_irq_counter_edges();
    test_backpressure();
    test_irq_wrap_sequences();
    test_random_traffic();
    repeat (10) @(posedge clk);
    if (mismatches == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule
